>>> rtl/core/rsoc_pkg.sv
// shared types and constants for the region sort and overlap check
`timescale 1ns / 1ps

package rsoc_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 48;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef struct packed {
        t_addr base;
        t_addr length;
        t_addr offset;
    } t_region;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

>>> rtl/core/region_sort_overlap_check.sv
// top level: region sort chain with overlap and overflow flags
`timescale 1ns / 1ps

// Regions load at one per cycle into a row of 16 cells that keeps them sorted by
// ascending base (equal bases stay in arrival order); a region arriving while all
// cells are full is dropped and remembered. The transfer marked last starts the
// drain: the row shifts toward cell 0 one position per cycle while the output is
// not stalled, and o_stall stays high on the input until the final region has
// moved into the output register. The final output carries the overlap flag
// (some end, base plus length without wrap, above the next base) and the
// overflow flag.

module region_sort_overlap_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [rsoc_pkg::ADDR_BITS-1:0] i_region_base,
    input  logic [rsoc_pkg::ADDR_BITS-1:0] i_region_length,
    input  logic [rsoc_pkg::ADDR_BITS-1:0] i_segment_offset,
    input  logic                      i_is_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [rsoc_pkg::ADDR_BITS-1:0] o_sorted_base,
    output logic [rsoc_pkg::ADDR_BITS-1:0] o_sorted_length,
    output logic [rsoc_pkg::ADDR_BITS-1:0] o_sorted_offset,
    output logic                      o_last_out,
    output logic                      o_overlap_found,
    output logic                      o_overflowed
);

    localparam int N = rsoc_pkg::MAX_REGIONS;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic                 r_dropped;
    logic                 r_hit;
    rsoc_pkg::t_region    r_out;
    logic                 r_last;
    logic                 r_overlap;
    logic                 r_overflow;

    rsoc_pkg::t_region    new_region;
    rsoc_pkg::t_cell_ctrl ctrl;
    rsoc_pkg::t_region    cell_region  [N];
    logic                 cell_valid   [N];
    logic                 cell_greater [N];
    logic                 in_xfer;
    logic                 full;
    logic                 pop;
    logic                 end_hit;
    logic [rsoc_pkg::ADDR_BITS:0] end_sum;

    assign new_region.base   = i_region_base;
    assign new_region.length = i_region_length;
    assign new_region.offset = i_segment_offset;

    assign o_stall  = (r_state == ST_DRAIN);
    assign in_xfer  = i_valid && !o_stall;
    assign full     = cell_valid[N-1];
    assign pop      = (r_state == ST_DRAIN) && (!r_out_valid || !i_stall);
    assign ctrl.ins = in_xfer && !full;
    assign ctrl.pop = pop;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            rsoc_pkg::t_region left_region;
            rsoc_pkg::t_region right_region;
            logic              left_valid;
            logic              left_greater;
            logic              right_valid;

            if (g == 0) begin : g_head
                assign left_region  = '0;
                assign left_valid   = 1'b1;
                assign left_greater = 1'b0;
            end else begin : g_mid
                assign left_region  = cell_region[g-1];
                assign left_valid   = cell_valid[g-1];
                assign left_greater = cell_greater[g-1];
            end

            if (g == N - 1) begin : g_tail
                assign right_region = '0;
                assign right_valid  = 1'b0;
            end else begin : g_body
                assign right_region = cell_region[g+1];
                assign right_valid  = cell_valid[g+1];
            end

            rsoc_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (ctrl),
                .i_new          (new_region),
                .i_left         (left_region),
                .i_left_valid   (left_valid),
                .i_left_greater (left_greater),
                .i_right        (right_region),
                .i_right_valid  (right_valid),
                .o_region       (cell_region[g]),
                .o_valid        (cell_valid[g]),
                .o_greater      (cell_greater[g])
            );
        end
    endgenerate

    // end of head region against base of the next one
    assign end_sum = {1'b0, cell_region[0].base} + {1'b0, cell_region[0].length};
    assign end_hit = cell_valid[1] && (end_sum > {1'b0, cell_region[1].base});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
            r_dropped   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_is_last) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (pop) begin
                        r_out       <= cell_region[0];
                        r_last      <= !cell_valid[1];
                        r_overlap   <= !cell_valid[1] && r_hit;
                        r_overflow  <= !cell_valid[1] && r_dropped;
                        if (cell_valid[1]) begin
                            r_hit <= r_hit || end_hit;
                        end else begin
                            r_hit     <= 1'b0;
                            r_dropped <= 1'b0;
                            r_state   <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sorted_base   = r_out.base;
    assign o_sorted_length = r_out.length;
    assign o_sorted_offset = r_out.offset;
    assign o_last_out      = r_last;
    assign o_overlap_found = r_overlap;
    assign o_overflowed    = r_overflow;

endmodule

>>> rtl/core/rsoc_cell.sv
// one cell of the sorted insertion row
`timescale 1ns / 1ps

module rsoc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsoc_pkg::t_cell_ctrl i_ctrl,
    input  rsoc_pkg::t_region   i_new,
    input  rsoc_pkg::t_region   i_left,
    input  logic                i_left_valid,
    input  logic                i_left_greater,
    input  rsoc_pkg::t_region   i_right,
    input  logic                i_right_valid,
    output rsoc_pkg::t_region   o_region,
    output logic                o_valid,
    output logic                o_greater
);

    rsoc_pkg::t_region r_region;
    rsoc_pkg::t_region n_region;
    logic              r_valid;
    logic              n_valid;
    logic              ins_here;

    assign o_greater = r_valid && (r_region.base > i_new.base);
    assign ins_here  = (o_greater || !r_valid) && i_left_valid && !i_left_greater;

    always_comb begin
        n_region = r_region;
        n_valid  = r_valid;
        if (i_ctrl.pop) begin
            n_region = i_right;
            n_valid  = i_right_valid;
        end else if (i_ctrl.ins) begin
            if (i_left_greater) begin
                n_region = i_left;
                n_valid  = 1'b1;
            end else if (ins_here) begin
                n_region = i_new;
                n_valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_region <= n_region;
    end

    assign o_region = r_region;
    assign o_valid  = r_valid;

endmodule

>>> verif/region_sort_overlap_check_tb.sv
// testbench for region_sort_overlap_check: sorted drain, overlap and overflow flags
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 76;
    localparam rsoc_pkg::t_addr ADDR_ONES = {rsoc_pkg::ADDR_BITS{1'b1}};

    typedef struct {
        rsoc_pkg::t_addr base;
        rsoc_pkg::t_addr length;
        rsoc_pkg::t_addr offset;
        logic  last;
        logic  typed;
        logic  exp_overlap;
        logic  exp_ovf;
    } t_plan_row;

    typedef struct {
        rsoc_pkg::t_addr base;
        rsoc_pkg::t_addr length;
        rsoc_pkg::t_addr offset;
        logic  last;
        logic  overlap;
        logic  ovf;
    } t_sorted_region;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    rsoc_pkg::t_addr i_region_base;
    rsoc_pkg::t_addr i_region_length;
    rsoc_pkg::t_addr i_segment_offset;
    logic  i_is_last;
    logic  o_valid;
    logic  i_stall;
    rsoc_pkg::t_addr o_sorted_base;
    rsoc_pkg::t_addr o_sorted_length;
    rsoc_pkg::t_addr o_sorted_offset;
    logic  o_last_out;
    logic  o_overlap_found;
    logic  o_overflowed;

    // flags typed in by the directed table, carried with the payload
    logic  typed_now;
    logic  typed_overlap;
    logic  typed_ovf;

    rsoc_pkg::t_addr list_base   [rsoc_pkg::MAX_REGIONS];
    rsoc_pkg::t_addr list_length [rsoc_pkg::MAX_REGIONS];
    rsoc_pkg::t_addr list_offset [rsoc_pkg::MAX_REGIONS];
    int    list_fill;
    logic  list_dropped;

    t_sorted_region awaited_regions[$];
    t_sorted_region next_expected;
    t_plan_row      directed_rows[$];

    int   errors;
    int   items_sent;
    int   cycle_count;
    int   hold_left;
    int   gap_left;
    logic took_result;
    logic no_idle;

    region_sort_overlap_check DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_region_base    (i_region_base),
        .i_region_length  (i_region_length),
        .i_segment_offset (i_segment_offset),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sorted_base    (o_sorted_base),
        .o_sorted_length  (o_sorted_length),
        .o_sorted_offset  (o_sorted_offset),
        .o_last_out       (o_last_out),
        .o_overlap_found  (o_overlap_found),
        .o_overflowed     (o_overflowed)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_plan_row make_row(input rsoc_pkg::t_addr b,
                                           input rsoc_pkg::t_addr l,
                                           input rsoc_pkg::t_addr o,
                                           input logic last, input logic typed,
                                           input logic ovl, input logic ovf);
        t_plan_row r;
        r.base = b;
        r.length = l;
        r.offset = o;
        r.last = last;
        r.typed = typed;
        r.exp_overlap = ovl;
        r.exp_ovf = ovf;
        return r;
    endfunction

    // insert into the sorted list; on the last region queue the whole drain
    function void absorb_region(input rsoc_pkg::t_addr b, input rsoc_pkg::t_addr l,
                                input rsoc_pkg::t_addr o,
                                input logic last, input logic typed,
                                input logic t_ovl, input logic t_ovf);
        int pos;
        logic hit;
        logic [rsoc_pkg::ADDR_BITS:0] end_addr;
        t_sorted_region r;
        if (list_fill >= rsoc_pkg::MAX_REGIONS) begin
            list_dropped = 1'b1;
        end else begin
            pos = list_fill;
            while (pos > 0 && list_base[pos-1] > b) begin
                list_base[pos] = list_base[pos-1];
                list_length[pos] = list_length[pos-1];
                list_offset[pos] = list_offset[pos-1];
                pos--;
            end
            list_base[pos] = b;
            list_length[pos] = l;
            list_offset[pos] = o;
            list_fill++;
        end
        if (last) begin
            hit = 1'b0;
            for (int i = 0; i + 1 < list_fill; i++) begin
                end_addr = {1'b0, list_base[i]} + {1'b0, list_length[i]};
                if (end_addr > {1'b0, list_base[i+1]}) begin
                    hit = 1'b1;
                end
            end
            for (int i = 0; i < list_fill; i++) begin
                r.base = list_base[i];
                r.length = list_length[i];
                r.offset = list_offset[i];
                r.last = (i == list_fill - 1);
                r.overlap = r.last && hit;
                r.ovf = r.last && list_dropped;
                if (r.last && typed) begin
                    r.overlap = t_ovl;
                    r.ovf = t_ovf;
                end
                awaited_regions.push_back(r);
            end
            list_fill = 0;
            list_dropped = 1'b0;
        end
    endfunction

    function void compare_field(input string name, input rsoc_pkg::t_addr exp_val,
                                input rsoc_pkg::t_addr act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endfunction

    function automatic rsoc_pkg::t_addr wide_value();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return ADDR_ONES;
            default: return rsoc_pkg::t_addr'({$urandom(), $urandom()});
        endcase
    endfunction

    task automatic drive_region(input t_plan_row row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_region_base = row.base;
        i_region_length = row.length;
        i_segment_offset = row.offset;
        i_is_last = row.last;
        typed_now = row.typed;
        typed_overlap = row.exp_overlap;
        typed_ovf = row.exp_ovf;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            absorb_region(i_region_base, i_region_length, i_segment_offset, i_is_last,
                          typed_now, typed_overlap, typed_ovf);
        end
    end

    // output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            took_result = 1'b1;
            if (awaited_regions.size() == 0) begin
                errors++;
                $display("%0t: unexpected output, expected none, actual base %h", $time,
                         o_sorted_base);
            end else begin
                next_expected = awaited_regions.pop_front();
                compare_field("sorted_base", next_expected.base, o_sorted_base);
                compare_field("sorted_length", next_expected.length, o_sorted_length);
                compare_field("sorted_offset", next_expected.offset, o_sorted_offset);
                compare_field("last_out", rsoc_pkg::t_addr'(next_expected.last),
                              rsoc_pkg::t_addr'(o_last_out));
                compare_field("overlap_found", rsoc_pkg::t_addr'(next_expected.overlap),
                              rsoc_pkg::t_addr'(o_overlap_found));
                compare_field("overflowed", rsoc_pkg::t_addr'(next_expected.ovf),
                              rsoc_pkg::t_addr'(o_overflowed));
            end
        end
    end

    // receiver: random stall after each transfer, plus long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (took_result) begin
                took_result = 1'b0;
                gap_left = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("region_sort_overlap_check regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int list_len;
        int mode;
        int list_no;
        rsoc_pkg::t_addr b;
        rsoc_pkg::t_addr l;
        t_plan_row row;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_region_base = '0;
        i_region_length = '0;
        i_segment_offset = '0;
        i_is_last = 1'b0;
        typed_now = 1'b0;
        typed_overlap = 1'b0;
        typed_ovf = 1'b0;
        list_fill = 0;
        list_dropped = 1'b0;
        errors = 0;
        items_sent = 0;
        hold_left = 0;
        gap_left = 0;
        took_result = 1'b0;
        no_idle = 1'b0;

        // single regions at both extremes
        directed_rows.push_back(make_row('0, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(make_row(ADDR_ONES, ADDR_ONES, ADDR_ONES, 1'b1, 1'b1, 1'b0,
                                         1'b0));
        // tie on equal bases, touching end, then overlap
        directed_rows.push_back(make_row(48'h1000, 48'h20, 48'h1, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(make_row(48'h1000, 48'h8, 48'h2, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(make_row(48'h0ff0, 48'h10, 48'h3, 1'b1, 1'b1, 1'b1, 1'b0));
        // end sum above the address range must not wrap
        directed_rows.push_back(make_row(48'hffff_ffff_f000, ADDR_ONES, 48'h5, 1'b0, 1'b0,
                                         1'b0, 1'b0));
        directed_rows.push_back(make_row(ADDR_ONES, '0, 48'h6, 1'b1, 1'b1, 1'b1, 1'b0));
        // full store, marked region dropped
        for (int i = 0; i <= rsoc_pkg::MAX_REGIONS; i++) begin
            row = make_row(rsoc_pkg::t_addr'((rsoc_pkg::MAX_REGIONS - i) * 'h100), 48'h10,
                           rsoc_pkg::t_addr'(i), i == rsoc_pkg::MAX_REGIONS,
                           i == rsoc_pkg::MAX_REGIONS, 1'b0, 1'b1);
            directed_rows.push_back(row);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            drive_region(directed_rows[k]);
        end

        list_no = 0;
        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            list_no++;
            no_idle = (list_no >= 10 && list_no <= 13);
            if (list_no == 8) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                while (awaited_regions.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: list_len = $urandom_range(rsoc_pkg::MAX_REGIONS, rsoc_pkg::MAX_REGIONS + 3);
                1: list_len = 1;
                default: list_len = $urandom_range(2, 6);
            endcase
            if (list_no == 4) begin
                list_len = 8;
                hold_left = 80;
            end
            mode = $urandom_range(0, 2);
            for (int i = 0; i < list_len; i++) begin
                case (mode)
                    0: begin
                        b = rsoc_pkg::t_addr'($urandom_range(0, 15) * 16);
                        l = rsoc_pkg::t_addr'($urandom_range(0, 40));
                    end
                    1: begin
                        b = wide_value();
                        l = wide_value();
                    end
                    default: begin
                        b = rsoc_pkg::t_addr'($urandom_range(0, 255)) << 12;
                        l = rsoc_pkg::t_addr'($urandom_range(0, 4096));
                    end
                endcase
                drive_region(make_row(b, l, wide_value(), i == list_len - 1, 1'b0, 1'b0,
                                      1'b0));
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (awaited_regions.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("region_sort_overlap_check regression: pass");
        end else begin
            $display("region_sort_overlap_check regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rsoc_pkg.sv
rtl/core/rsoc_cell.sv
rtl/core/region_sort_overlap_check.sv
verif/region_sort_overlap_check_tb.sv
